@@ design/qmul_pkg.sv @@
`default_nettype none
package qmul_pkg;

  // Exact product component: four 16x16 products summed
  localparam int PROD_W = 34;
  // Aligned magnitude: largest component has its msb at bit 30
  localparam int MAG_W  = 31;
  localparam int ALIGN_MSB = 30;
  // Sum of four squared aligned magnitudes
  localparam int SQ_W   = 64;
  // Integer square root of the sum
  localparam int ROOT_W = 32;
  // Number of root bits resolved, one per stage
  localparam int ROOT_STEPS = 32;

  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    logic [3:0] neg;   // sign of each product component
    logic [1:0] zero;  // zero operand flags
  } side_t;

  typedef struct packed {
    mag_t [3:0] mag;
    side_t      side;
  } norm_t;

endpackage
`default_nettype wire

@@ design/qmul_if.sv @@
`default_nettype none
interface qmul_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] a_w;
  logic signed [15:0] a_x;
  logic signed [15:0] a_y;
  logic signed [15:0] a_z;
  logic signed [15:0] b_w;
  logic signed [15:0] b_x;
  logic signed [15:0] b_y;
  logic signed [15:0] b_z;

  modport source (output valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, input ready);
  modport sink   (input valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, output ready);
endinterface

interface qmul_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] r_w;
  logic signed [15:0] r_x;
  logic signed [15:0] r_y;
  logic signed [15:0] r_z;
  logic        [1:0]  zero_operand;

  modport source (output valid, r_w, r_x, r_y, r_z, zero_operand, input ready);
  modport sink   (input valid, r_w, r_x, r_y, r_z, zero_operand, output ready);
endinterface
`default_nettype wire

@@ design/normalized_quaternion_multiply_unit.sv @@
`default_nettype none
// Normalized quaternion multiply.
// in_i carries a pair of quaternions (a, b) in signed fixed point; out_o carries the
// unit quaternion in the direction of the Hamilton product a*b with FRAC_BITS fraction
// bits, plus a flag per operand that was all zero and was taken as (1,0,0,0).
// Both channels use valid/ready; a transfer happens when both are high.
// Throughput: one transfer per cycle each way while the output register is not stalled.
// Pipeline, in order: partial products and Hamilton sums, magnitudes and their
// alignment, squares and their sum, 32 square-root stages (one root bit each), the
// dividend setup, FRAC_BITS + 2 divider stages (one quotient bit each) and the
// output register.
// in_i.ready drops, and the whole pipeline holds, only while the output register is
// full and not being taken, so nothing is lost or repeated.
// Reset clears every stage valid bit; the data registers are not reset.
module normalized_quaternion_multiply_unit #(
  parameter int FRAC_BITS = 14
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  qmul_in_if.sink   in_i,
  qmul_out_if.source out_o
);

  logic                                    adv;
  logic                                    prod_vld;
  logic signed [3:0][qmul_pkg::PROD_W-1:0] prod_p;
  logic [1:0]                              prod_zero;
  logic                                    aln_vld;
  qmul_pkg::norm_t                         aln_norm;
  logic                                    rt_vld;
  logic [qmul_pkg::ROOT_W-1:0]             rt_root;
  qmul_pkg::norm_t                         rt_norm;
  logic                                    div_vld;
  logic signed [3:0][15:0]                 div_r;
  logic [1:0]                              div_zero;
  logic signed [3:0][15:0]                 in_a;
  logic signed [3:0][15:0]                 in_b;

  // Pipeline advances unless the output register is full and stalled
  assign adv        = !div_vld || out_o.ready;
  assign in_i.ready = adv;

  assign in_a = {in_i.a_z, in_i.a_y, in_i.a_x, in_i.a_w};
  assign in_b = {in_i.b_z, in_i.b_y, in_i.b_x, in_i.b_w};

  qmul_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_i.valid),
    .a_i     (in_a),
    .b_i     (in_b),
    .valid_o (prod_vld),
    .p_o     (prod_p),
    .zero_o  (prod_zero)
  );

  qmul_align u_align (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (prod_vld),
    .p_i     (prod_p),
    .zero_i  (prod_zero),
    .valid_o (aln_vld),
    .norm_o  (aln_norm)
  );

  qmul_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (aln_vld),
    .norm_i  (aln_norm),
    .valid_o (rt_vld),
    .root_o  (rt_root),
    .norm_o  (rt_norm)
  );

  qmul_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (rt_vld),
    .root_i  (rt_root),
    .norm_i  (rt_norm),
    .valid_o (div_vld),
    .r_o     (div_r),
    .zero_o  (div_zero)
  );

  assign out_o.valid        = div_vld;
  assign out_o.r_w          = div_r[0];
  assign out_o.r_x          = div_r[1];
  assign out_o.r_y          = div_r[2];
  assign out_o.r_z          = div_r[3];
  assign out_o.zero_operand = div_zero;

  // Both operands replaced by identity gives a pure scalar result
  a_both_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_vld && (div_zero == 2'b11)) |->
      (div_r[1] == 16'sd0) && (div_r[2] == 16'sd0) && (div_r[3] == 16'sd0))
    else $error("identity product has vector part");

endmodule
`default_nettype wire

@@ design/qmul_prod.sv @@
`default_nettype none
module qmul_prod (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    en_i,
  input  wire                                    valid_i,
  input  wire  logic signed [3:0][15:0]          a_i,
  input  wire  logic signed [3:0][15:0]          b_i,
  output logic                                   valid_o,
  output logic signed [3:0][qmul_pkg::PROD_W-1:0] p_o,
  output logic [1:0]                             zero_o
);

  logic signed [15:0] a_sub [4];
  logic signed [15:0] b_sub [4];
  logic [1:0]         zero_d;
  logic signed [31:0] pr_q [4][4];
  logic [1:0]         zero1_q;
  logic               vld1_q;
  logic               vld2_q;
  logic signed [qmul_pkg::PROD_W-1:0] p_d [4];
  logic signed [qmul_pkg::PROD_W-1:0] p_q [4];
  logic [1:0]         zero2_q;

  // Zero operand detection and identity substitution
  always_comb begin
    zero_d[0] = (a_i == '0);
    zero_d[1] = (b_i == '0);
    for (int i = 0; i < 4; i++) begin
      a_sub[i] = a_i[i];
      b_sub[i] = b_i[i];
    end
    if (zero_d[0]) a_sub[0] = 16'sd1;
    if (zero_d[1]) b_sub[0] = 16'sd1;
  end

  // Stage 1: all sixteen partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pr_q[i][j] <= a_sub[i] * b_sub[j];
        end
      end
      zero1_q <= zero_d;
    end
  end

  // Hamilton product sums
  always_comb begin
    p_d[0] = 34'(pr_q[0][0]) - 34'(pr_q[1][1]) - 34'(pr_q[2][2]) - 34'(pr_q[3][3]);
    p_d[1] = 34'(pr_q[1][0]) + 34'(pr_q[0][1]) - 34'(pr_q[3][2]) + 34'(pr_q[2][3]);
    p_d[2] = 34'(pr_q[2][0]) + 34'(pr_q[3][1]) + 34'(pr_q[0][2]) - 34'(pr_q[1][3]);
    p_d[3] = 34'(pr_q[3][0]) - 34'(pr_q[2][1]) + 34'(pr_q[1][2]) + 34'(pr_q[0][3]);
  end

  // Stage 2: product components
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) p_q[i] <= p_d[i];
      zero2_q <= zero1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) p_o[i] = p_q[i];
  end
  assign valid_o = vld2_q;
  assign zero_o  = zero2_q;

endmodule
`default_nettype wire

@@ design/qmul_align.sv @@
`default_nettype none
module qmul_align (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    en_i,
  input  wire                                    valid_i,
  input  wire  logic signed [3:0][qmul_pkg::PROD_W-1:0] p_i,
  input  wire  logic [1:0]                       zero_i,
  output logic                                   valid_o,
  output qmul_pkg::norm_t                        norm_o
);

  localparam int AW = qmul_pkg::PROD_W - 1;

  logic [AW-1:0]   abs_d [4];
  logic [AW-1:0]   max_d;
  logic [AW-1:0]   abs_q [4];
  logic [AW-1:0]   max_q;
  qmul_pkg::side_t side_q;
  logic            vld1_q;
  logic [5:0]      msb;
  logic [AW+qmul_pkg::ALIGN_MSB-1:0] wide;
  qmul_pkg::norm_t norm_d;
  qmul_pkg::norm_t norm_q;
  logic            vld2_q;

  // Magnitudes and their maximum
  always_comb begin
    max_d = '0;
    for (int i = 0; i < 4; i++) begin
      abs_d[i] = p_i[i][qmul_pkg::PROD_W-1] ? AW'(-p_i[i]) : AW'(p_i[i]);
      if (abs_d[i] > max_d) max_d = abs_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        abs_q[i]       <= abs_d[i];
        side_q.neg[i]  <= p_i[i][qmul_pkg::PROD_W-1];
      end
      max_q       <= max_d;
      side_q.zero <= zero_i;
    end
  end

  // Leading one of the maximum, then shift so it lands on the align bit
  always_comb begin
    msb = '0;
    for (int b = 0; b < AW; b++) begin
      if (max_q[b]) msb = 6'(b);
    end
    norm_d.side = side_q;
    for (int i = 0; i < 4; i++) begin
      wide = {abs_q[i], {qmul_pkg::ALIGN_MSB{1'b0}}} >> msb;
      norm_d.mag[i] = wide[qmul_pkg::MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) norm_q <= norm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  assign valid_o = vld2_q;
  assign norm_o  = norm_q;

endmodule
`default_nettype wire

@@ design/qmul_isqrt.sv @@
`default_nettype none
module qmul_isqrt (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            en_i,
  input  wire                            valid_i,
  input  wire  qmul_pkg::norm_t          norm_i,
  output logic                           valid_o,
  output logic [qmul_pkg::ROOT_W-1:0]    root_o,
  output qmul_pkg::norm_t                norm_o
);

  localparam int NS = qmul_pkg::ROOT_STEPS;
  localparam int SW = qmul_pkg::SQ_W;

  logic [2*qmul_pkg::MAG_W-1:0] sq_q [4];
  qmul_pkg::norm_t              sqn_q;
  logic                         sqv_q;

  // Root pipeline: index 0 holds the sum of squares
  logic [SW-1:0]   rem_q  [NS+1];
  logic [SW-1:0]   res_q  [NS+1];
  qmul_pkg::norm_t nrm_q  [NS+1];
  logic            vld_q  [NS+1];

  // Squares of the aligned magnitudes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) sq_q[i] <= norm_i.mag[i] * norm_i.mag[i];
      sqn_q <= norm_i;
    end
  end

  // Sum of squares
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]) + SW'(sq_q[3]);
      res_q[0] <= '0;
      nrm_q[0] <= sqn_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqv_q    <= 1'b0;
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      sqv_q    <= valid_i;
      vld_q[0] <= sqv_q;
    end
  end

  // One root bit per stage, digit-by-digit
  for (genvar s = 0; s < NS; s++) begin : g_step
    localparam logic [SW-1:0] BIT_C = SW'(1) << (SW - 2 - 2 * s);
    logic [SW-1:0] trial;
    logic          take;

    assign trial = res_q[s] + BIT_C;
    assign take  = (rem_q[s] >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= take ? rem_q[s] - trial : rem_q[s];
        res_q[s+1] <= take ? (res_q[s] >> 1) + BIT_C : res_q[s] >> 1;
        nrm_q[s+1] <= nrm_q[s];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
  end

  assign valid_o = vld_q[NS];
  assign root_o  = res_q[NS][qmul_pkg::ROOT_W-1:0];
  assign norm_o  = nrm_q[NS];

  // Aligned input keeps the root at or above 2^30
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS] |-> (res_q[NS][qmul_pkg::ROOT_W-1:qmul_pkg::ROOT_W-2] != 2'b00))
    else $error("root below alignment range");

endmodule
`default_nettype wire

@@ design/qmul_div.sv @@
`default_nettype none
module qmul_div #(
  parameter int FRAC_BITS = 14
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              en_i,
  input  wire                              valid_i,
  input  wire  logic [qmul_pkg::ROOT_W-1:0] root_i,
  input  wire  qmul_pkg::norm_t            norm_i,
  output logic                             valid_o,
  output logic signed [3:0][15:0]          r_o,
  output logic [1:0]                       zero_o
);

  localparam int QW = FRAC_BITS + 2;             // quotient bits
  localparam int NW = qmul_pkg::MAG_W + 1 + FRAC_BITS; // rounded dividend
  localparam int RW = qmul_pkg::ROOT_W + 1;      // partial remainder

  logic [RW-1:0]             rem_q  [QW+1][4];
  logic [QW-1:0]             sh_q   [QW+1][4];
  logic [qmul_pkg::ROOT_W-1:0] root_q [QW+1];
  qmul_pkg::side_t           side_q [QW+1];
  logic                      vld_q  [QW+1];
  logic [NW-1:0]             num    [4];

  logic signed [3:0][15:0]   r_q;
  logic [1:0]                zero_q;
  logic                      out_vld_q;
  logic [63:0]               qx     [4];

  // Dividend with half the divisor added for rounding
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      num[l] = (NW'(norm_i.mag[l]) << FRAC_BITS) + NW'(root_i >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 4; l++) begin
        rem_q[0][l] <= RW'(num[l][NW-1:QW]);
        sh_q[0][l]  <= num[l][QW-1:0];
      end
      root_q[0] <= root_i;
      side_q[0] <= norm_i.side;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  // Restoring division, one quotient bit per stage in each lane
  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [RW-1:0] trial [4];
    logic          ge    [4];

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        trial[l] = {rem_q[s][l][RW-2:0], sh_q[s][l][QW-1]};
        ge[l]    = (trial[l] >= RW'(root_q[s]));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 4; l++) begin
          rem_q[s+1][l] <= ge[l] ? trial[l] - RW'(root_q[s]) : trial[l];
          sh_q[s+1][l]  <= {sh_q[s][l][QW-2:0], ge[l]};
        end
        root_q[s+1] <= root_q[s];
        side_q[s+1] <= side_q[s];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
  end

  // Apply sign and saturate to 16 bits; this is the output register
  always_comb begin
    for (int l = 0; l < 4; l++) qx[l] = 64'(sh_q[QW][l]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 4; l++) begin
        if (side_q[QW].neg[l]) begin
          r_q[l] <= (qx[l] > 64'd32768) ? 16'h8000 : 16'(64'd0 - qx[l]);
        end else begin
          r_q[l] <= (qx[l] > 64'd32767) ? 16'h7fff : qx[l][15:0];
        end
      end
      zero_q <= side_q[QW].zero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[QW];
    end
  end

  assign valid_o = out_vld_q;
  assign r_o     = r_q;
  assign zero_o  = zero_q;

  // Final partial remainders stay below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[QW] |-> (rem_q[QW][0] < RW'(root_q[QW])) && (rem_q[QW][1] < RW'(root_q[QW]))
               && (rem_q[QW][2] < RW'(root_q[QW])) && (rem_q[QW][3] < RW'(root_q[QW])))
    else $error("division remainder out of range");

  // A unit vector component never exceeds one
  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[QW] |-> (qx[0] <= (64'd1 << FRAC_BITS)) && (qx[1] <= (64'd1 << FRAC_BITS))
               && (qx[2] <= (64'd1 << FRAC_BITS)) && (qx[3] <= (64'd1 << FRAC_BITS)))
    else $error("quotient above unit");

endmodule
`default_nettype wire

@@ tb/normalized_quaternion_multiply_unit_tb.sv @@
module normalized_quaternion_multiply_unit_tb;

  localparam int FRAC_BITS = 14;
  localparam int LATENCY = FRAC_BITS + 42;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [1:0]         zero_operand;
  } unit_quat_t;

  // Scoreboard: predicts the unit product and checks results in order
  class unit_product_board;
    unit_quat_t pending_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function longint unsigned root64(longint unsigned n);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
        if (n >= res + bit_v) begin
          n -= res + bit_v;
          res = (res >> 1) + bit_v;
        end else begin
          res >>= 1;
        end
        bit_v >>= 2;
      end
      return res;
    endfunction

    function void note_pair(logic signed [15:0] av[4], logic signed [15:0] bv[4]);
      longint a[4], b[4], p[4];
      longint unsigned mag[4], m, s, n, q;
      logic [1:0] flags;
      logic signed [15:0] r[4];
      unit_quat_t e;
      flags = '0;
      for (int i = 0; i < 4; i++) begin
        a[i] = av[i];
        b[i] = bv[i];
      end
      if (a[0] == 0 && a[1] == 0 && a[2] == 0 && a[3] == 0) begin
        a[0] = 1;
        flags[0] = 1'b1;
      end
      if (b[0] == 0 && b[1] == 0 && b[2] == 0 && b[3] == 0) begin
        b[0] = 1;
        flags[1] = 1'b1;
      end
      p[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
      p[1] = a[1]*b[0] + a[0]*b[1] - a[3]*b[2] + a[2]*b[3];
      p[2] = a[2]*b[0] + a[3]*b[1] + a[0]*b[2] - a[1]*b[3];
      p[3] = a[3]*b[0] - a[2]*b[1] + a[1]*b[2] + a[0]*b[3];
      m = 0;
      for (int i = 0; i < 4; i++) begin
        mag[i] = (p[i] < 0) ? -p[i] : p[i];
        if (mag[i] > m) m = mag[i];
      end
      // align largest magnitude to bit 30
      while (m >= (64'd1 << 31)) begin
        m >>= 1;
        for (int i = 0; i < 4; i++) mag[i] >>= 1;
      end
      while (m != 0 && m < (64'd1 << 30)) begin
        m <<= 1;
        for (int i = 0; i < 4; i++) mag[i] <<= 1;
      end
      s = 0;
      for (int i = 0; i < 4; i++) s += mag[i] * mag[i];
      n = root64(s);
      if (n == 0) n = 1;
      for (int i = 0; i < 4; i++) begin
        q = ((mag[i] << FRAC_BITS) + (n >> 1)) / n;
        if (p[i] < 0) r[i] = (q > 32768) ? 16'sh8000 : 16'(-q);
        else r[i] = (q > 32767) ? 16'sd32767 : 16'(q);
      end
      e.w = r[0];
      e.x = r[1];
      e.y = r[2];
      e.z = r[3];
      e.zero_operand = flags;
      pending_q.push_back(e);
    endfunction

    function void check_result(unit_quat_t got);
      unit_quat_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.w !== e.w || got.x !== e.x || got.y !== e.y || got.z !== e.z ||
          got.zero_operand !== e.zero_operand) begin
        $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d zero=%0d", $time,
                 e.w, e.x, e.y, e.z, e.zero_operand);
        $display("%0t:          actual   w=%0d x=%0d y=%0d z=%0d zero=%0d", $time,
                 got.w, got.x, got.y, got.z, got.zero_operand);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  qmul_in_if  pair_if ();
  qmul_out_if prod_if ();

  normalized_quaternion_multiply_unit #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pair_if.sink),
    .out_o (prod_if.source)
  );

  unit_product_board board;
  bit calm_phase;
  int cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Input transfers and result checks at the rising edge
  always @(posedge clk_i) begin
    logic signed [15:0] av[4], bv[4];
    unit_quat_t got;
    if (rst_ni) begin
      if (pair_if.valid && pair_if.ready) begin
        av = '{pair_if.a_w, pair_if.a_x, pair_if.a_y, pair_if.a_z};
        bv = '{pair_if.b_w, pair_if.b_x, pair_if.b_y, pair_if.b_z};
        board.note_pair(av, bv);
      end
      if (prod_if.valid && prod_if.ready) begin
        got.w = prod_if.r_w;
        got.x = prod_if.r_x;
        got.y = prod_if.r_y;
        got.z = prod_if.r_z;
        got.zero_operand = prod_if.zero_operand;
        board.check_result(got);
      end
    end
  end

  // Receiver: random stall bursts, none in the calm phase
  initial begin
    int stall;
    prod_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
        prod_if.ready = 1'b0;
        stall = $urandom_range(1, 5);
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        prod_if.ready = 1'b1;
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_pair(logic signed [15:0] a[4], logic signed [15:0] b[4]);
    int gap;
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      pair_if.valid = 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk_i);
    end
    pair_if.valid = 1'b1;
    {pair_if.a_w, pair_if.a_x, pair_if.a_y, pair_if.a_z} = {a[0], a[1], a[2], a[3]};
    {pair_if.b_w, pair_if.b_x, pair_if.b_y, pair_if.b_z} = {b[0], b[1], b[2], b[3]};
    do @(posedge clk_i); while (!pair_if.ready);
    @(negedge clk_i);
    pair_if.valid = 1'b0;
  endtask

  // Random component: half full range, the rest extremes, zero and small values
  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd0;
      3: return 16'($urandom_range(0, 7) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic wait_drain();
    while (board.pending_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic signed [15:0] a[4], b[4];
    logic signed [15:0] mx, mn;
    board = new();
    calm_phase = 0;
    pair_if.valid = 1'b0;
    {pair_if.a_w, pair_if.a_x, pair_if.a_y, pair_if.a_z} = '0;
    {pair_if.b_w, pair_if.b_x, pair_if.b_y, pair_if.b_z} = '0;
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    mx = 16'sh7fff;
    mn = 16'sh8000;

    // Directed: zero operands, identity, extremes, basis products
    a = '{0, 0, 0, 0};       b = '{0, 0, 0, 0};       send_pair(a, b);
    a = '{0, 0, 0, 0};       b = '{1, 2, 3, 4};       send_pair(a, b);
    a = '{-5, 7, 0, 1};      b = '{0, 0, 0, 0};       send_pair(a, b);
    a = '{16384, 0, 0, 0};   b = '{16384, 0, 0, 0};   send_pair(a, b);
    a = '{mx, mx, mx, mx};   b = '{mx, mx, mx, mx};   send_pair(a, b);
    a = '{mn, mn, mn, mn};   b = '{mn, mn, mn, mn};   send_pair(a, b);
    a = '{mn, mx, mn, mx};   b = '{mx, mn, mx, mn};   send_pair(a, b);
    a = '{0, 16384, 0, 0};   b = '{0, 16384, 0, 0};   send_pair(a, b);
    a = '{0, 0, 16384, 0};   b = '{0, 0, 0, 16384};   send_pair(a, b);
    a = '{0, 0, 0, mn};      b = '{0, mx, 0, 0};      send_pair(a, b);
    a = '{1, 0, 0, 0};       b = '{0, 0, 0, 1};       send_pair(a, b);
    a = '{-1, -1, -1, -1};   b = '{1, -1, 1, -1};     send_pair(a, b);
    a = '{mn, 0, 0, 0};      b = '{mn, 0, 0, 0};      send_pair(a, b);
    a = '{3, 0, 0, 4};       b = '{0, 5, 12, 0};      send_pair(a, b);
    a = '{-16'sd1, 16'sh5555, 16'sh2aaa, 16'sh1234};
    b = '{16'sh4321, -16'sd2, 16'sh0f0f, 16'sh7000};  send_pair(a, b);

    // Hold off until the pipeline is empty
    wait_drain();

    for (int k = 0; k < 1000; k++) begin
      if (k == 500) wait_drain();
      if (k == 850) calm_phase = 1;
      for (int i = 0; i < 4; i++) begin
        a[i] = rand_comp();
        b[i] = rand_comp();
      end
      if ($urandom_range(0, 40) == 0) a = '{0, 0, 0, 0};
      if ($urandom_range(0, 40) == 0) b = '{0, 0, 0, 0};
      send_pair(a, b);
    end

    for (int t = 0; t < 20 * LATENCY + 1000 && board.pending_q.size() != 0; t++)
      @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
